// ----- rtl/poi_pkg.sv -----
package poi_pkg;

  // field widths
  localparam int unsigned VelW  = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned TimeW = 16;
  localparam int unsigned PosW  = 32;
  localparam int unsigned AngW  = 16;

  // datapath widths
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned AccW  = 64;
  localparam int unsigned DtW   = 33;
  localparam int unsigned CordW = 33;
  localparam int unsigned CfgIdxW = 1;

  // fixed-point shifts
  localparam int unsigned VelShift     = 12;
  localparam int unsigned HdShift      = 44;
  localparam int unsigned KShift       = 30;
  localparam int unsigned PosShift     = 26;
  localparam int unsigned CordPreShift = 14;
  localparam int unsigned SplitW       = 15;

  // rounding offsets
  localparam logic signed [MulPW-1:0] VelRound = MulPW'(1) <<< (VelShift - 1);
  localparam logic signed [MulPW-1:0] PosRound = MulPW'(1) <<< (PosShift - 1);
  localparam logic signed [AccW-1:0]  HdRound  = AccW'(1) <<< (HdShift - 1);
  localparam logic signed [AccW-1:0]  KRound   = AccW'(1) <<< (KShift - 1);

  // radians to binary angle (2^44 scale) and cordic gain correction (Q1.30),
  // both split in two halves for the narrow multiplier
  localparam int RadToBam = 683565276;
  localparam int CordicK  = 652032874;
  localparam int RadLo    = RadToBam % (1 << SplitW);
  localparam int RadHi    = RadToBam / (1 << SplitW);
  localparam int KLo      = CordicK % (1 << SplitW);
  localparam int KHi      = CordicK / (1 << SplitW);

  // saturation bounds
  localparam logic signed [VelW-1:0] VelMax = {1'b0, {(VelW - 1){1'b1}}};
  localparam logic signed [VelW-1:0] VelMin = {1'b1, {(VelW - 1){1'b0}}};
  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW - 1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW - 1){1'b0}}};

  localparam logic signed [GainW-1:0] GainReset = GainW'(4096);

  // arctangent table, 2^32 = 2pi
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned AtanIdxW    = 5;
  localparam logic [31:0] AtanBam [AtanEntries] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
    32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef enum logic {
    OP_ADVANCE = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINEAR_GAIN  = 1'b0,
    CFG_ANGULAR_GAIN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                     operation;
    logic signed [VelW-1:0]  lin_x;
    logic signed [VelW-1:0]  lin_y;
    logic signed [VelW-1:0]  ang_z;
    logic [TimeW-1:0]        elapsed;
    logic signed [PosW-1:0]  init_x;
    logic signed [PosW-1:0]  init_y;
    logic [AngW-1:0]         init_heading;
  } in_req_t;

  typedef struct packed {
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic [AngW-1:0]         heading;
    logic signed [VelW-1:0]  vel_x_scaled;
    logic signed [VelW-1:0]  vel_y_scaled;
    logic signed [VelW-1:0]  ang_scaled;
  } out_rsp_t;

  typedef struct packed {
    logic init;
    logic step;
  } cordic_ctrl_t;

  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [MulPW-1:0] v);
    logic signed [VelW-1:0] r;
    if (v > MulPW'(VelMax)) begin
      r = VelMax;
    end else if (v < MulPW'(VelMin)) begin
      r = VelMin;
    end else begin
      r = v[VelW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [MulPW-1:0] v);
    logic signed [PosW-1:0] r;
    if (v > MulPW'(PosMax)) begin
      r = PosMax;
    end else if (v < MulPW'(PosMin)) begin
      r = PosMin;
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/poi_in_if.sv -----
interface poi_in_if import poi_pkg::*;;
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/poi_out_if.sv -----
interface poi_out_if import poi_pkg::*;;
  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/poi_mul.sv -----
module poi_mul import poi_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [MulPW-1:0] p_o
);

  logic signed [MulPW-1:0] p_q;

  // shared signed multiplier, product registered
  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/poi_cordic.sv -----
module poi_cordic import poi_pkg::*; #(
  parameter int unsigned Iterations = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cordic_ctrl_t            ctrl_i,
  input  logic signed [VelW-1:0]  vx_i,
  input  logic signed [VelW-1:0]  vy_i,
  input  logic [AngW-1:0]         heading_i,
  output logic                    done_o,
  output logic signed [CordW-1:0] x_o,
  output logic signed [CordW-1:0] y_o
);

  localparam int unsigned CntW = $clog2(Iterations + 1);

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic signed [CordW-1:0] x_d, y_d, z_d;
  logic                    flip;
  logic [AngW-1:0]         ang_adj;
  logic signed [CordW-1:0] x_pre, y_pre, z_init;
  logic [AtanIdxW-1:0]     idx;
  logic signed [CordW-1:0] xs, ys, atan_s;

  // fold the left half plane onto the right one by negating the vector
  assign flip    = heading_i[AngW-1] ^ heading_i[AngW-2];
  assign ang_adj = {heading_i[AngW-1] ^ flip, heading_i[AngW-2:0]};
  assign x_pre   = CordW'(vx_i) <<< CordPreShift;
  assign y_pre   = CordW'(vy_i) <<< CordPreShift;
  assign z_init  = {ang_adj[AngW-1], ang_adj, {(CordW - AngW - 1){1'b0}}};

  // one rotation step per cycle while ctrl_i.step is set
  assign idx    = AtanIdxW'(cnt_q);
  assign xs     = x_q >>> idx;
  assign ys     = y_q >>> idx;
  assign atan_s = CordW'(AtanBam[idx]);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    cnt_d = cnt_q;
    if (ctrl_i.init) begin
      x_d   = flip ? -x_pre : x_pre;
      y_d   = flip ? -y_pre : y_pre;
      z_d   = z_init;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      if (z_q >= 0) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_s;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_s;
      end
      cnt_d = cnt_q + CntW'(1);
    end
  end

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // vector and angle registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = (cnt_q == CntW'(Iterations));
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// ----- rtl/planar_odometry_integrator.sv -----
// Dead-reckoning pose integrator. An advance request scales its velocities
// by the linear and angular gains, moves the heading by the scaled yaw rate
// times the elapsed time, rotates the scaled planar velocity by the new
// heading in a CORDIC unit and adds the rotated velocity times the elapsed
// time to the saturating x and y positions; a load request sets the pose.
// Every request returns one result with the pose after it and the scaled
// velocities (zero for a load). One request is in flight at a time: the
// block is ready again only once the result has been loaded into the output
// register, which waits while a stalled earlier result still holds it. An
// advance request runs a chain of products on the single shared multiplier
// and the CORDIC unit, which does one rotation step per cycle. A finished
// result waits in the output register while the next request is accepted.
// Gains are written on the plain write port and must only change while idle.
module planar_odometry_integrator import poi_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  poi_in_if.sink             req_i,
  poi_out_if.source          rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_wdata_i
);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_VX    = 5'd1;
  localparam logic [4:0] S_VY    = 5'd2;
  localparam logic [4:0] S_VA    = 5'd3;
  localparam logic [4:0] S_VW    = 5'd4;
  localparam logic [4:0] S_DT    = 5'd5;
  localparam logic [4:0] S_DW    = 5'd6;
  localparam logic [4:0] S_HLO   = 5'd7;
  localparam logic [4:0] S_HHI   = 5'd8;
  localparam logic [4:0] S_HACC  = 5'd9;
  localparam logic [4:0] S_HUPD  = 5'd10;
  localparam logic [4:0] S_CINIT = 5'd11;
  localparam logic [4:0] S_CRUN  = 5'd12;
  localparam logic [4:0] S_KXLO  = 5'd13;
  localparam logic [4:0] S_KXHI  = 5'd14;
  localparam logic [4:0] S_KYLO  = 5'd15;
  localparam logic [4:0] S_KYHI  = 5'd16;
  localparam logic [4:0] S_PX    = 5'd17;
  localparam logic [4:0] S_PY    = 5'd18;
  localparam logic [4:0] S_PW    = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  logic [4:0]              state_q, state_d;
  logic signed [GainW-1:0] lin_gain_q, ang_gain_q;
  logic signed [PosW-1:0]  pos_x_q, pos_y_q;
  logic [AngW-1:0]         heading_q;
  logic                    out_valid_q, out_valid_d;
  out_rsp_t                out_q;

  in_req_t                 item_q;
  logic signed [VelW-1:0]  vxs_q, vys_q, vths_q;
  logic signed [DtW-1:0]   d_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [PosW-1:0]  rx_q, ry_q;

  logic                    req_hs;
  logic                    out_load;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;
  logic signed [MulBW-1:0] el_b;
  logic signed [MulPW-1:0] vel_rnd;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  acc_sum;
  logic signed [MulPW-1:0] pos_step;
  logic signed [PosW-1:0]  pos_cur;
  logic signed [PosW-1:0]  pos_new;
  cordic_ctrl_t            crd_ctrl;
  logic                    crd_done;
  logic signed [CordW-1:0] crd_x, crd_y;

  assign req_hs   = req_i.valid && req_i.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  // shared multiplier
  poi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // cordic rotator
  assign crd_ctrl.init = (state_q == S_CINIT);
  assign crd_ctrl.step = (state_q == S_CRUN) && !crd_done;

  poi_cordic #(
    .Iterations (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (crd_ctrl),
    .vx_i      (vxs_q),
    .vy_i      (vys_q),
    .heading_i (heading_q),
    .done_o    (crd_done),
    .x_o       (crd_x),
    .y_o       (crd_y)
  );

  // multiplier operand selection
  assign el_b = {{(MulBW - TimeW){1'b0}}, item_q.elapsed};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_VX: begin
        mul_a = MulAW'(item_q.lin_x);
        mul_b = MulBW'(lin_gain_q);
      end
      S_VY: begin
        mul_a = MulAW'(item_q.lin_y);
        mul_b = MulBW'(lin_gain_q);
      end
      S_VA: begin
        mul_a = MulAW'(item_q.ang_z);
        mul_b = MulBW'(ang_gain_q);
      end
      S_DT: begin
        mul_a = MulAW'(vths_q);
        mul_b = el_b;
      end
      S_HLO: begin
        mul_a = MulAW'(d_q);
        mul_b = MulBW'(RadLo);
      end
      S_HHI: begin
        mul_a = MulAW'(d_q);
        mul_b = MulBW'(RadHi);
      end
      S_KXLO: begin
        mul_a = MulAW'(crd_x);
        mul_b = MulBW'(KLo);
      end
      S_KXHI: begin
        mul_a = MulAW'(crd_x);
        mul_b = MulBW'(KHi);
      end
      S_KYLO: begin
        mul_a = MulAW'(crd_y);
        mul_b = MulBW'(KLo);
      end
      S_KYHI: begin
        mul_a = MulAW'(crd_y);
        mul_b = MulBW'(KHi);
      end
      S_PX: begin
        mul_a = MulAW'(rx_q);
        mul_b = el_b;
      end
      S_PY: begin
        mul_a = MulAW'(ry_q);
        mul_b = el_b;
      end
      default: ;
    endcase
  end

  // rounding and accumulation of products
  assign vel_rnd  = (prod + VelRound) >>> VelShift;
  assign prod_ext = AccW'(prod);
  assign acc_sum  = acc_q + (prod_ext <<< SplitW);
  assign pos_step = (prod + PosRound) >>> PosShift;
  assign pos_cur  = (state_q == S_PW) ? pos_y_q : pos_x_q;
  assign pos_new  = sat_pos(MulPW'(pos_cur) + pos_step);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_hs) begin
          state_d = (req_i.data.operation == OP_LOAD) ? S_DONE : S_VX;
        end
      end
      S_VX:    state_d = S_VY;
      S_VY:    state_d = S_VA;
      S_VA:    state_d = S_VW;
      S_VW:    state_d = S_DT;
      S_DT:    state_d = S_DW;
      S_DW:    state_d = S_HLO;
      S_HLO:   state_d = S_HHI;
      S_HHI:   state_d = S_HACC;
      S_HACC:  state_d = S_HUPD;
      S_HUPD:  state_d = S_CINIT;
      S_CINIT: state_d = S_CRUN;
      S_CRUN: begin
        if (crd_done) begin
          state_d = S_KXLO;
        end
      end
      S_KXLO:  state_d = S_KXHI;
      S_KXHI:  state_d = S_KYLO;
      S_KYLO:  state_d = S_KYHI;
      S_KYHI:  state_d = S_PX;
      S_PX:    state_d = S_PY;
      S_PY:    state_d = S_PW;
      S_PW:    state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output slot: a new result takes priority over clearing
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // sequencer, gains and pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lin_gain_q  <= GainReset;
      ang_gain_q  <= GainReset;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_LINEAR_GAIN:  lin_gain_q <= cfg_wdata_i;
          CFG_ANGULAR_GAIN: ang_gain_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_IDLE && req_hs && req_i.data.operation == OP_LOAD) begin
        pos_x_q   <= req_i.data.init_x;
        pos_y_q   <= req_i.data.init_y;
        heading_q <= req_i.data.init_heading;
      end
      if (state_q == S_HUPD) begin
        heading_q <= heading_q + acc_q[HdShift+AngW-1:HdShift];
      end
      if (state_q == S_PY) begin
        pos_x_q <= pos_new;
      end
      if (state_q == S_PW) begin
        pos_y_q <= pos_new;
      end
    end
  end

  // working registers of the current request
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (req_hs) begin
          item_q <= req_i.data;
          vxs_q  <= '0;
          vys_q  <= '0;
          vths_q <= '0;
        end
      end
      S_VY:   vxs_q  <= sat_vel(vel_rnd);
      S_VA:   vys_q  <= sat_vel(vel_rnd);
      S_VW:   vths_q <= sat_vel(vel_rnd);
      S_DW:   d_q    <= prod[DtW-1:0];
      S_HHI:  acc_q  <= prod_ext + HdRound;
      S_HACC: acc_q  <= acc_sum;
      S_KXHI: acc_q  <= prod_ext + KRound;
      S_KYLO: rx_q   <= acc_sum[KShift+PosW-1:KShift];
      S_KYHI: acc_q  <= prod_ext + KRound;
      S_PX:   ry_q   <= acc_sum[KShift+PosW-1:KShift];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pos_x        <= pos_x_q;
      out_q.pos_y        <= pos_y_q;
      out_q.heading      <= heading_q;
      out_q.vel_x_scaled <= vxs_q;
      out_q.vel_y_scaled <= vys_q;
      out_q.ang_scaled   <= vths_q;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ----- rtl/poi_checker.sv -----
module poi_checker import poi_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     req_valid_i,
  input logic     req_ready_i,
  input in_req_t  req_data_i,
  input logic     rsp_valid_i,
  input logic     rsp_ready_i,
  input out_rsp_t rsp_data_i
);

  // one request at a time: busy right after an accepted request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while previous one in flight");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result changed or dropped while stalled");

  // a load into an empty output slot shows the loaded pose, by way of the done state and the result register
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_data_i.operation == OP_LOAD && !rsp_valid_i
    |=> ##1 rsp_valid_i
        && rsp_data_i.pos_x == $past(req_data_i.init_x, 2)
        && rsp_data_i.pos_y == $past(req_data_i.init_y, 2)
        && rsp_data_i.heading == $past(req_data_i.init_heading, 2)
        && rsp_data_i.vel_x_scaled == '0
        && rsp_data_i.vel_y_scaled == '0
        && rsp_data_i.ang_scaled == '0)
    else $error("load result does not match loaded pose");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_data_i  (req_i.data),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
